FILE: rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, codes and the microcode table shared by the Sv39 walker modules.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned EntryBits = 9;
  localparam int unsigned PpnW      = 44;
  localparam int unsigned PhysW     = 56;
  localparam int unsigned VaW       = 39;
  localparam int unsigned PteW      = 64;
  localparam int unsigned WidxW     = 13;
  localparam int unsigned PageOffW  = 12;

  localparam int unsigned PteValidBit = 0;
  localparam int unsigned PteUserBit  = 4;
  localparam int unsigned PtePpnLsb   = 10;

  localparam logic [1:0] LvlTop  = 2'd2;
  localparam logic [1:0] LvlMid  = 2'd1;
  localparam logic [1:0] LvlLeaf = 2'd0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HIGH     = 3'd1,
    ST_MISSING  = 3'd2,
    ST_INVALID  = 3'd3,
    ST_NOT_USER = 3'd4,
    ST_OUTSIDE  = 3'd5
  } status_e;

  typedef enum logic {
    CFG_ROOT_PAGE    = 1'b0,
    CFG_REQUIRE_USER = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE     = 1'b0,
    ACT_TRANSLATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_DISPATCH,
    OP_POINTER,
    OP_LEAF
  } op_e;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_WALK2,
    STEP_WALK1,
    STEP_LEAF
  } step_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] rd_level;
    step_e      next;
  } ucode_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] rd_level;
    logic       clearing;
  } ctrl_t;

  typedef struct packed {
    logic              action;
    logic [WidxW-1:0]  word_index;
    logic [PteW-1:0]   entry_word;
    logic [VaW-1:0]    virt_addr;
  } in_t;

  typedef struct packed {
    logic [PhysW-1:0] phys_page_addr;
    status_e          status;
  } out_t;

  // Microcode: the read issued in each step and where the walk goes next.
  function automatic ucode_t ucode_rom(step_e step);
    ucode_t uc;
    case (step)
      STEP_IDLE:  uc = '{op: OP_DISPATCH, rd_level: LvlTop,  next: STEP_WALK2};
      STEP_WALK2: uc = '{op: OP_POINTER,  rd_level: LvlMid,  next: STEP_WALK1};
      STEP_WALK1: uc = '{op: OP_POINTER,  rd_level: LvlLeaf, next: STEP_LEAF};
      STEP_LEAF:  uc = '{op: OP_LEAF,     rd_level: LvlLeaf, next: STEP_IDLE};
      default:    uc = '{op: OP_DISPATCH, rd_level: LvlTop,  next: STEP_IDLE};
    endcase
    return uc;
  endfunction

  function automatic logic [EntryBits-1:0] vpn_index(logic [VaW-1:0] va, logic [1:0] level);
    logic [EntryBits-1:0] idx;
    case (level)
      LvlTop:  idx = va[38:30];
      LvlMid:  idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/ptw_ram.sv
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ptw_sequencer.sv
// ----------------------------------------------------------------------------
// ptw_sequencer
// Step counter over the microcode table, plus the store clearing pass.
// ----------------------------------------------------------------------------
module ptw_sequencer import ptw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 16,
  localparam int unsigned StoreWords = TABLE_PAGES * 512,
  localparam int unsigned StoreAw    = $clog2(StoreWords)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               fin_i,
  output logic               busy_o,
  output ctrl_t              ctrl_o,
  output logic [StoreAw-1:0] clr_addr_o
);

  step_e               step_q, step_d;
  logic                clearing_q, clearing_d;
  logic [StoreAw-1:0]  clr_q, clr_d;
  ucode_t              uc;
  logic                advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_IDLE;
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      step_q     <= step_d;
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_comb begin
    uc = ucode_rom(step_q);
    if (uc.op == OP_DISPATCH) begin
      advance = accept_i && !fin_i;
    end else begin
      advance = !fin_i;
    end
    step_d = advance ? uc.next : STEP_IDLE;

    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == StoreAw'(StoreWords - 1)) begin
        clearing_d = 1'b0;
      end
    end

    ctrl_o = '{op: uc.op, rd_level: uc.rd_level, clearing: clearing_q};
    busy_o = clearing_q || (step_q != STEP_IDLE);
  end

  assign clr_addr_o = clr_q;

endmodule

FILE: rtl/ptw_datapath.sv
// ----------------------------------------------------------------------------
// ptw_datapath
// Table store, configuration registers, entry checks and the result register.
// ----------------------------------------------------------------------------
module ptw_datapath import ptw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 16,
  localparam int unsigned StoreWords = TABLE_PAGES * 512,
  localparam int unsigned StoreAw    = $clog2(StoreWords)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic [StoreAw-1:0] clr_addr_i,
  input  logic               accept_i,
  input  in_t                item_i,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_index_i,
  input  logic [PpnW-1:0]    cfg_data_i,
  output logic               fin_o,
  output logic               result_valid_o,
  output out_t               result_o
);

  logic [PpnW-1:0]      root_q;
  logic                 user_q;
  logic [VaW-1:0]       va_q;
  logic                 valid_q;
  out_t                 result_q, result_d;
  logic [PteW-1:0]      rdata;
  logic [PpnW-1:0]      rd_ppn;
  logic [PpnW-1:0]      page_src;
  logic [VaW-1:0]       va_src;
  logic [EntryBits-1:0] idx;
  logic                 page_out;
  logic [StoreAw-1:0]   raddr;
  logic                 we;
  logic [StoreAw-1:0]   waddr;
  logic [PteW-1:0]      wdata;
  logic                 fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      user_q  <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROOT_PAGE:    root_q <= cfg_data_i;
          CFG_REQUIRE_USER: user_q <= cfg_data_i[0];
          default:          root_q <= root_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      va_q <= item_i.virt_addr;
    end
    if (fin) begin
      result_q <= result_d;
    end
  end

  always_comb begin
    rd_ppn = rdata[PtePpnLsb +: PpnW];
    if (ctrl_i.op == OP_DISPATCH) begin
      page_src = root_q;
      va_src   = item_i.virt_addr;
    end else begin
      page_src = rd_ppn;
      va_src   = va_q;
    end
    idx      = vpn_index(va_src, ctrl_i.rd_level);
    page_out = page_src >= PpnW'(TABLE_PAGES);
    raddr    = StoreAw'({page_src, idx});
  end

  always_comb begin
    if (ctrl_i.clearing) begin
      we    = 1'b1;
      waddr = clr_addr_i;
      wdata = '0;
    end else begin
      we    = accept_i && (item_i.action == ACT_WRITE)
              && (32'(item_i.word_index) < 32'(StoreWords));
      waddr = StoreAw'(item_i.word_index);
      wdata = item_i.entry_word;
    end
  end

  always_comb begin
    fin      = 1'b0;
    result_d = '{phys_page_addr: '0, status: ST_OK};
    case (ctrl_i.op)
      OP_DISPATCH: begin
        if (accept_i) begin
          if (item_i.action == ACT_WRITE) begin
            fin = 1'b1;
          end else if (item_i.virt_addr[VaW-1]) begin
            fin             = 1'b1;
            result_d.status = ST_HIGH;
          end else if (page_out) begin
            fin             = 1'b1;
            result_d.status = ST_OUTSIDE;
          end
        end
      end
      OP_POINTER: begin
        if (!rdata[PteValidBit]) begin
          fin             = 1'b1;
          result_d.status = ST_MISSING;
        end else if (page_out) begin
          fin             = 1'b1;
          result_d.status = ST_OUTSIDE;
        end
      end
      OP_LEAF: begin
        fin = 1'b1;
        if (!rdata[PteValidBit]) begin
          result_d.status = ST_INVALID;
        end else if (user_q && !rdata[PteUserBit]) begin
          result_d.status = ST_NOT_USER;
        end else begin
          result_d.phys_page_addr = {rd_ppn, {PageOffW{1'b0}}};
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  ptw_ram #(
    .WIDTH(PteW),
    .DEPTH(StoreWords)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign fin_o          = fin;
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

FILE: rtl/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Translates 39-bit virtual addresses through a three-level Sv39 table held
// in an internal store of TABLE_PAGES pages of 512 entries. An item is taken
// when start_i is high and busy_o is low. A write item loads one table word.
// A translation reads the top, middle and leaf entries one after another from
// the single registered read port of the table RAM and then checks the leaf
// entry; a fault ends the walk early. Each result appears on result_o for
// one cycle, flagged by result_valid_o, in the cycle after its item's last
// step, and the receiver must take it then. After reset the store is cleared
// one word per cycle, with busy_o high; configuration writes are taken
// throughout.
// ----------------------------------------------------------------------------
module sv39_page_table_walker import ptw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  in_t             item_i,
  output logic            result_valid_o,
  output out_t            result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  cfg_idx_e        cfg_index_i,
  input  logic [PpnW-1:0] cfg_data_i
);

  localparam int unsigned StoreAw = $clog2(TABLE_PAGES * 512);

  logic               accept;
  logic               fin;
  ctrl_t              ctrl;
  logic [StoreAw-1:0] clr_addr;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  ptw_sequencer #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .fin_i     (fin),
    .busy_o    (busy_o),
    .ctrl_o    (ctrl),
    .clr_addr_o(clr_addr)
  );

  ptw_datapath #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .clr_addr_i    (clr_addr),
    .accept_i      (accept),
    .item_i        (item_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fin_o         (fin),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

`ifndef ASSERT_OFF
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clearing |-> !result_valid_o)
    else $error("Result beat during the store clearing pass.");

  a_leaf_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_LEAF) |=> result_valid_o)
    else $error("Leaf step did not produce a result beat.");

  a_walk_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.action == ACT_TRANSLATE) && !fin) |=> (ctrl.op == OP_POINTER))
    else $error("Accepted translation did not enter the walk.");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.action == ACT_WRITE)) |=> (result_valid_o && result_o.status == ST_OK))
    else $error("Write item did not return an OK beat.");
`endif

endmodule

FILE: verif/sv39_page_table_walker_tb.sv
// ----------------------------------------------------------------------------
// sv39_page_table_walker_tb
// Self-checking bench for the Sv39 walker. A queue of write and translate
// beats is built for each phase: directed corner cases first, then random
// walks and lone beats. Each walk loads a top, middle and leaf entry and
// then translates through them. A predictor with its own copy of the table
// store and the registers works out each result when the beat is taken.
// Results are compared in order with these predictions. Between phases
// the root page and user check change, and the sender idles at several rates.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_tb;
  import ptw_pkg::*;

  localparam int unsigned TablePages = 16;
  localparam int unsigned StoreWords = TablePages * 512;
  localparam int unsigned QuietLimit = 40000;
  localparam logic [VaW-1:0] DirVa = {1'b0, 8'hFF, 9'h1FF, 9'h000, 12'hFFF};
  localparam logic [PteW-1:0] DirFlags = 64'hFFC0_0000_0000_001E;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  in_t             item_i = '0;
  logic            result_valid_o;
  out_t            result_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  cfg_idx_e        cfg_index_i = CFG_ROOT_PAGE;
  logic [PpnW-1:0] cfg_data_i = '0;

  logic [PteW-1:0] store_mirror [StoreWords] = '{default: '0};
  logic [PpnW-1:0] root_ppn = '0;
  logic            need_user = 1'b1;

  in_t         pending_beats[$];
  out_t        walk_results_q[$];
  out_t        oldest_result;
  int          awaiting_results = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  sv39_page_table_walker #(
    .TABLE_PAGES(TablePages)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .item_i,
    .result_valid_o,
    .result_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  function automatic out_t predict_translation(in_t b);
    out_t r;
    logic [PteW-1:0] pte;
    logic [PpnW-1:0] page;
    logic [EntryBits-1:0] vpn;
    r.phys_page_addr = '0;
    r.status = ST_OK;
    pte = '0;
    if (b.action == ACT_WRITE) begin
      if (b.word_index < StoreWords) store_mirror[b.word_index] = b.entry_word;
      return r;
    end
    if (b.virt_addr[VaW-1]) begin
      r.status = ST_HIGH;
      return r;
    end
    page = root_ppn;
    for (int lvl = 2; lvl >= 0; lvl--) begin
      vpn = b.virt_addr[PageOffW + EntryBits * lvl +: EntryBits];
      if (page >= TablePages) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      pte = store_mirror[int'(page) * 512 + int'(vpn)];
      if (lvl > 0) begin
        if (!pte[PteValidBit]) begin
          r.status = ST_MISSING;
          return r;
        end
        page = pte[PtePpnLsb +: PpnW];
      end
    end
    if (!pte[PteValidBit]) begin
      r.status = ST_INVALID;
    end else if (need_user && !pte[PteUserBit]) begin
      r.status = ST_NOT_USER;
    end else begin
      r.phys_page_addr = {pte[PtePpnLsb +: PpnW], {PageOffW{1'b0}}};
    end
    return r;
  endfunction

  function automatic in_t write_beat(logic [WidxW-1:0] idx, logic [PteW-1:0] word);
    in_t b;
    b.action = ACT_WRITE;
    b.word_index = idx;
    b.entry_word = word;
    b.virt_addr = VaW'({$urandom, $urandom});
    return b;
  endfunction

  function automatic in_t translate_beat(logic [VaW-1:0] va);
    in_t b;
    b.action = ACT_TRANSLATE;
    b.word_index = WidxW'($urandom);
    b.entry_word = {$urandom, $urandom};
    b.virt_addr = va;
    return b;
  endfunction

  function automatic void queue_beat(in_t b);
    pending_beats.push_back(b);
    awaiting_results++;
  endfunction

  function automatic logic [PteW-1:0] pointer_pte(logic [PpnW-1:0] ppn, logic valid,
                                                  logic [PteW-1:0] flags);
    logic [PteW-1:0] w;
    w = flags;
    w[PtePpnLsb +: PpnW] = ppn;
    w[PteValidBit] = valid;
    return w;
  endfunction

  function automatic logic [PpnW-1:0] pick_table_page();
    if ($urandom_range(19) == 0) return PpnW'({$urandom, $urandom});
    return PpnW'($urandom_range(TablePages));
  endfunction

  function automatic int queue_walk();
    logic [3:0] top_pg;
    logic [EntryBits-1:0] v2, v1, v0;
    logic [PpnW-1:0] mid_pg, leaf_pg;
    logic [PteW-1:0] leaf;
    int reps;
    top_pg = (root_ppn < TablePages) ? root_ppn[3:0] : 4'($urandom_range(TablePages - 1));
    v2 = EntryBits'($urandom_range(255));
    v1 = EntryBits'($urandom);
    v0 = EntryBits'($urandom);
    mid_pg = pick_table_page();
    leaf_pg = pick_table_page();
    leaf = {$urandom, $urandom};
    leaf[PtePpnLsb +: PpnW] = PpnW'({$urandom, $urandom});
    leaf[PteValidBit] = ($urandom_range(7) != 0);
    reps = $urandom_range(1, 3);
    queue_beat(write_beat({top_pg, v2},
                          pointer_pte(mid_pg, $urandom_range(15) != 0, {$urandom, $urandom})));
    queue_beat(write_beat({mid_pg[3:0], v1},
                          pointer_pte(leaf_pg, $urandom_range(15) != 0, {$urandom, $urandom})));
    queue_beat(write_beat({leaf_pg[3:0], v0}, leaf));
    for (int i = 0; i < reps; i++) begin
      queue_beat(translate_beat({1'b0, v2[7:0], v1, v0, 12'($urandom)}));
    end
    return reps + 3;
  endfunction

  function automatic int queue_random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return queue_walk();
    if (pick < 75) begin
      queue_beat(translate_beat({1'b0, (VaW - 1)'({$urandom, $urandom})}));
    end else if (pick < 90) begin
      queue_beat(write_beat(WidxW'($urandom), {$urandom, $urandom}));
    end else begin
      queue_beat(translate_beat({1'b1, (VaW - 1)'({$urandom, $urandom})}));
    end
    return 1;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (awaiting_results > 0);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [PpnW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ROOT_PAGE) begin
      root_ppn = data;
    end else begin
      need_user = data[0];
    end
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [PpnW-1:0] root, logic user, int unsigned idle, int n);
    int queued;
    queued = 0;
    wait_drained();
    cfg_write(CFG_ROOT_PAGE, root);
    cfg_write(CFG_REQUIRE_USER, PpnW'(user));
    sender_idle_pct = idle;
    while (queued < n) queued += queue_random_burst();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
    end else begin
      if (start_i && !busy_o) walk_results_q.push_back(predict_translation(item_i));
      if (!start_i || !busy_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start_i <= 1'b1;
          item_i  <= pending_beats.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      awaiting_results--;
      if (walk_results_q.size() == 0) begin
        report_mismatch("result beat with no translation outstanding");
      end else begin
        oldest_result = walk_results_q.pop_front();
        if (result_o.phys_page_addr !== oldest_result.phys_page_addr) begin
          report_mismatch($sformatf("phys_page_addr %h, predicted %h",
                                    result_o.phys_page_addr, oldest_result.phys_page_addr));
        end
        if (result_o.status !== oldest_result.status) begin
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    result_o.status, oldest_result.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_write(CFG_ROOT_PAGE, '0);
    cfg_write(CFG_REQUIRE_USER, PpnW'(1));
    sender_idle_pct = 22;

    queue_beat(translate_beat('0));
    queue_beat(translate_beat('1));
    queue_beat(translate_beat(39'h40_0000_0000));
    queue_beat(write_beat({4'd0, 9'h0FF}, pointer_pte(PpnW'(3), 1'b1, DirFlags)));
    queue_beat(write_beat({4'd3, 9'h1FF}, pointer_pte(PpnW'(15), 1'b1, DirFlags)));
    queue_beat(write_beat({4'd15, 9'h000}, '1));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat({4'd15, 9'h000}, 64'hFFFF_FFFF_FFFF_FFEF));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat({4'd15, 9'h000}, 64'hFFFF_FFFF_FFFF_FFFE));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat({4'd15, 9'h000}, 64'h11));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat({4'd3, 9'h1FF}, pointer_pte(PpnW'(16), 1'b1, DirFlags)));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat({4'd3, 9'h1FF}, '0));
    queue_beat(translate_beat(DirVa));
    queue_beat(write_beat('1, '1));
    queue_beat(write_beat('0, '0));
    queue_beat(write_beat({4'd3, 9'h1FF}, pointer_pte(PpnW'(15), 1'b1, DirFlags)));
    queue_beat(write_beat({4'd15, 9'h000}, 64'h1));
    queue_beat(translate_beat(DirVa));
    wait_drained();
    cfg_write(CFG_REQUIRE_USER, '0);
    queue_beat(translate_beat(DirVa));
    wait_drained();
    cfg_write(CFG_ROOT_PAGE, '1);
    queue_beat(translate_beat(DirVa));

    run_phase('0, 1'b1, 22, 110);
    run_phase(PpnW'(15), 1'b0, 22, 110);
    run_phase(PpnW'($urandom_range(1, 14)), 1'b1, 47, 110);
    run_phase('1, 1'b1, 47, 25);
    run_phase(PpnW'($urandom_range(TablePages - 1)), 1'b0, 0, 110);
    run_phase(PpnW'(TablePages), 1'b0, 0, 25);
    run_phase('0, 1'b1, 0, 110);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (walk_results_q.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", walk_results_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
